/* hdl/tese_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tese_pkg
// Shared types, codes and the attribute (SGR) update function.
// ----------------------------------------------------------------------------
package tese_pkg;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 22;
  localparam int WORD_W = ATTR_W + CHAR_W;
  localparam int TOK_W  = 16;

  localparam logic [ATTR_W-1:0] PEN_RESET  = 22'h00ffff;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [WORD_W-1:0] RESET_WORD = {PEN_RESET, CH_SPACE};

  // configuration register indexes
  localparam logic [0:0] REG_COLUMNS = 1'b0;
  localparam logic [0:0] REG_ROWS    = 1'b1;

  // parser phases
  localparam logic [1:0] PH_GROUND = 2'd0;
  localparam logic [1:0] PH_ESC    = 2'd1;
  localparam logic [1:0] PH_CSI    = 2'd2;

  // control bytes
  localparam logic [7:0] B_NUL  = 8'h00;
  localparam logic [7:0] B_BS   = 8'h08;
  localparam logic [7:0] B_TAB  = 8'h09;
  localparam logic [7:0] B_LF   = 8'h0a;
  localparam logic [7:0] B_CR   = 8'h0d;
  localparam logic [7:0] B_ESC  = 8'h1b;
  localparam logic [7:0] B_LBR  = 8'h5b;
  localparam logic [7:0] B_SEMI = 8'h3b;
  localparam logic [7:0] B_M    = 8'h6d;
  localparam logic [7:0] B_ZERO = 8'h30;
  localparam logic [7:0] B_NINE = 8'h39;

  typedef struct packed {
    logic       start;
    logic       digit;
    logic       next;
    logic       apply;
    logic [3:0] digit_val;
  } pen_cmd_t;

  typedef struct packed {
    logic busy;
    logic room;
  } pen_stat_t;

  function automatic logic [ATTR_W-1:0] sgr_apply(input logic [ATTR_W-1:0] pen,
                                                  input logic [TOK_W-1:0]  v);
    logic [ATTR_W-1:0] p;
    p = pen;
    if (v == 16'd0) begin
      p = PEN_RESET;
    end else if (v >= 16'd1 && v <= 16'd5) begin
      p[15 + 32'(v[2:0])] = 1'b1;
    end else if (v == 16'd7) begin
      p[21] = 1'b1;
    end else if (v >= 16'd21 && v <= 16'd25) begin
      p[32'(v[4:0]) - 5] = 1'b0;
    end else if (v == 16'd27) begin
      p[21] = 1'b0;
    end else if (v >= 16'd30 && v <= 16'd37) begin
      p[7:0] = 8'(v - 16'd30);
    end else if (v == 16'd39) begin
      p[7:0] = 8'hff;
    end else if (v >= 16'd40 && v <= 16'd47) begin
      p[15:8] = 8'(v - 16'd40);
    end else if (v == 16'd49) begin
      p[15:8] = 8'hff;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

/* hdl/tese_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tese_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tese_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* hdl/tese_pen.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tese_pen
// Escape parameter store and drawing attribute; applies tokens one a cycle.
// ----------------------------------------------------------------------------
module tese_pen
  import tese_pkg::*;
#(
  parameter int MAX_TOKENS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pen_cmd_t          cmd,
  output logic      [ATTR_W-1:0] pen,
  output pen_stat_t              stat
);

  localparam int TIW = $clog2(MAX_TOKENS);

  logic [TOK_W-1:0] tok [MAX_TOKENS];
  logic [TIW-1:0]   tok_idx;
  logic [TIW-1:0]   apply_idx;
  logic             busy;
  logic [TIW-1:0]   sel;
  logic [TOK_W-1:0] tok_rd;
  logic [19:0]      acc;

  assign sel    = busy ? apply_idx : tok_idx;
  assign tok_rd = tok[sel];
  // v*10 + d
  assign acc = {1'b0, tok_rd, 3'b000} + {3'b000, tok_rd, 1'b0} + 20'(cmd.digit_val);

  assign stat.busy = busy;
  assign stat.room = (tok_idx != TIW'(MAX_TOKENS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      pen       <= PEN_RESET;
      tok_idx   <= '0;
      apply_idx <= '0;
      busy      <= 1'b0;
    end else if (busy) begin
      pen <= sgr_apply(pen, tok_rd);
      if (apply_idx == tok_idx) begin
        busy <= 1'b0;
      end
      apply_idx <= apply_idx + 1'b1;
    end else begin
      if (cmd.start) begin
        tok_idx <= '0;
        tok[0]  <= '0;
      end
      if (cmd.digit) begin
        tok[tok_idx] <= (acc > 20'd65535) ? 16'hffff : acc[15:0];
      end
      if (cmd.next) begin
        tok_idx                <= tok_idx + 1'b1;
        tok[tok_idx + 1'b1]    <= '0;
      end
      if (cmd.apply) begin
        apply_idx <= '0;
        busy      <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/terminal_escape_screen_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_escape_screen_engine
// Terminal byte parser driving a character/attribute screen store.
//
// Input channel (in_valid/in_stall): opcode 0 feeds one terminal byte,
// opcode 1 reads one cell. Every item gives exactly one result on the output
// channel (out_valid/out_stall) with the cursor after the item.
// Config: cfg_write with cfg_index/cfg_data, taken at any edge, no wait.
// One item is in progress at a time; the next transfer is taken once the
// result register is empty and the sequencer is back in idle.
// Plain bytes go through exec and emit; a printable adds a store write and
// an inside cell read a store read; an SGR terminator waits while the pen
// applies its tokens; a tab blanks cells to the next tab stop; a scroll
// copies rows up through the single store port pair (one read, one write a
// cycle) and blanks the bottom row. After reset the MAX_COLS*MAX_ROWS cells
// (8192 by default) are swept to blanks, one cell a cycle, with in_stall high.
// A stalled result holds in the output register and blocks new transfers.
// ----------------------------------------------------------------------------
module terminal_escape_screen_engine
  import tese_pkg::*;
#(
  parameter int MAX_COLS   = 128,
  parameter int MAX_ROWS   = 64,
  parameter int MAX_TOKENS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [7:0]  data_byte,
  input  wire logic [5:0]  read_row,
  input  wire logic [6:0]  read_col,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       cell_char,
  output logic [21:0]      cell_attr,
  output logic [7:0]       cursor_col,
  output logic [5:0]       cursor_row,
  output logic             read_outside
);

  localparam int CELLS = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int AC    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int RUW   = $clog2(MAX_ROWS + 1);
  localparam logic [AW-1:0] COLS_A  = AW'(MAX_COLS);
  localparam logic [AC-1:0] COLS_C  = AC'(MAX_COLS);

  localparam logic [3:0] S_CLEAR     = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_EXEC      = 4'd2;
  localparam logic [3:0] S_READ      = 4'd3;
  localparam logic [3:0] S_TAB       = 4'd4;
  localparam logic [3:0] S_SCROLL    = 4'd5;
  localparam logic [3:0] S_SCROLL_WR = 4'd6;
  localparam logic [3:0] S_PUT       = 4'd7;
  localparam logic [3:0] S_SGR       = 4'd8;
  localparam logic [3:0] S_EMIT      = 4'd9;

  function automatic logic [CW-1:0] clamp_cols(input logic [7:0] v);
    logic [8:0] w;
    w = {1'b0, v};
    if (w == 9'd0) return CW'(1);
    if (w > 9'(MAX_COLS)) return CW'(MAX_COLS);
    return CW'(w);
  endfunction

  function automatic logic [RUW-1:0] clamp_rows(input logic [6:0] v);
    logic [7:0] w;
    w = {1'b0, v};
    if (w == 8'd0) return RUW'(1);
    if (w > 8'(MAX_ROWS)) return RUW'(MAX_ROWS);
    return RUW'(w);
  endfunction

  logic [3:0]        state;
  logic [7:0]        cols_reg;
  logic [6:0]        rows_reg;
  logic [CW-1:0]     cols_used;
  logic [RUW-1:0]    rows_used;
  logic [CW-1:0]     cur_col;
  logic [RW-1:0]     cur_row;
  logic [1:0]        phase;
  logic              it_op;
  logic [7:0]        it_byte;
  logic [5:0]        it_row;
  logic [6:0]        it_col;
  logic [AC-1:0]     addr;
  logic [AC-1:0]     copy_end;
  logic [AC-1:0]     fill_end;
  logic              pend_print;
  logic [7:0]        res_char;
  logic [ATTR_W-1:0] res_attr;
  logic              res_out;

  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;

  pen_cmd_t          pen_cmd;
  pen_stat_t         pen_stat;
  logic [ATTR_W-1:0] pen;

  logic              in_xfer;
  logic              b_digit;
  logic              b_csi_ok;
  logic              is_ground;
  logic              outside;
  logic              at_bottom;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     cell_addr;
  logic [CW-1:0]     col_inc;
  logic [CW-1:0]     new_cols;
  logic [RUW-1:0]    new_rows;

  assign cols_used = clamp_cols(cols_reg);
  assign rows_used = clamp_rows(rows_reg);
  assign in_stall  = !(state == S_IDLE && !out_valid);
  assign in_xfer   = in_valid && !in_stall;

  assign b_digit  = (it_byte >= B_ZERO) && (it_byte <= B_NINE);
  assign b_csi_ok = b_digit || (it_byte == B_SEMI && pen_stat.room) || (it_byte == B_M);
  assign is_ground = !((phase == PH_ESC && it_byte == B_LBR) ||
                       (phase == PH_CSI && b_csi_ok));
  assign outside   = (8'(it_row) >= 8'(rows_used)) || (9'(it_col) >= 9'(cols_used));
  assign at_bottom = (RUW'(cur_row) == rows_used - 1'b1);
  assign cur_addr  = AW'(cur_row) * COLS_A + AW'(cur_col);
  assign cell_addr = AW'(it_row) * COLS_A + AW'(it_col);
  assign col_inc   = cur_col + 1'b1;
  assign new_cols  = (cfg_index == REG_COLUMNS) ? clamp_cols(cfg_data) : cols_used;
  assign new_rows  = (cfg_index == REG_ROWS) ? clamp_rows(cfg_data[6:0]) : rows_used;

  always_comb begin
    pen_cmd           = '0;
    pen_cmd.digit_val = 4'(it_byte - B_ZERO);
    if (state == S_EXEC && !it_op) begin
      pen_cmd.start = (phase == PH_ESC) && (it_byte == B_LBR);
      pen_cmd.digit = (phase == PH_CSI) && b_digit;
      pen_cmd.next  = (phase == PH_CSI) && (it_byte == B_SEMI) && pen_stat.room;
      pen_cmd.apply = (phase == PH_CSI) && (it_byte == B_M);
    end
  end

  // store port control
  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = cur_addr;
    ram_wr_data = {pen, CH_SPACE};
    ram_rd_en   = 1'b0;
    ram_rd_addr = cell_addr;
    unique case (state)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = addr[AW-1:0];
        ram_wr_data = RESET_WORD;
      end
      S_EXEC: begin
        ram_rd_en = it_op && !outside;
      end
      S_TAB: begin
        ram_wr_en = 1'b1;
      end
      S_PUT: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = {pen, it_byte};
      end
      S_SCROLL: begin
        ram_rd_addr = addr[AW-1:0] + COLS_A;
        ram_wr_addr = addr[AW-1:0];
        if (addr < copy_end) begin
          ram_rd_en = 1'b1;
        end else if (addr < fill_end) begin
          ram_wr_en = 1'b1;
        end
      end
      S_SCROLL_WR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = addr[AW-1:0];
        ram_wr_data = ram_rd_data;
      end
      default: begin
      end
    endcase
  end

  tese_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELLS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  tese_pen #(
    .MAX_TOKENS (MAX_TOKENS)
  ) u_pen (
    .clk  (clk),
    .rst  (rst),
    .cmd  (pen_cmd),
    .pen  (pen),
    .stat (pen_stat)
  );

  always_ff @(posedge clk) begin
    if (it_op == 1'b0 && state == S_IDLE) begin
      res_out <= 1'b0;
    end
    if (in_xfer) begin
      it_op    <= opcode;
      it_byte  <= data_byte;
      it_row   <= read_row;
      it_col   <= read_col;
      res_char <= '0;
      res_attr <= '0;
      res_out  <= 1'b0;
    end
    if (state == S_READ) begin
      res_char <= ram_rd_data[CHAR_W-1:0];
      res_attr <= ram_rd_data[WORD_W-1:CHAR_W];
    end
    if (state == S_EXEC && it_op) begin
      res_out <= outside;
    end
    if (state == S_EMIT) begin
      cell_char    <= res_char;
      cell_attr    <= res_attr;
      cursor_col   <= 8'(cur_col);
      cursor_row   <= 6'(cur_row);
      read_outside <= res_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      addr       <= '0;
      cols_reg   <= 8'd80;
      rows_reg   <= 7'd24;
      cur_col    <= '0;
      cur_row    <= '0;
      phase      <= PH_GROUND;
      pend_print <= 1'b0;
      out_valid  <= 1'b0;
      copy_end   <= '0;
      fill_end   <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == AC'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state      <= S_EMIT;
          pend_print <= 1'b0;
          if (it_op) begin
            if (!outside) begin
              state <= S_READ;
            end
          end else if (!is_ground) begin
            if (phase == PH_ESC) begin
              phase <= PH_CSI;
            end else if (it_byte == B_M) begin
              phase <= PH_GROUND;
              state <= S_SGR;
            end
          end else begin
            phase <= PH_GROUND;
            priority case (it_byte)
              B_NUL: begin
              end
              B_BS: begin
                if (cur_col != '0) cur_col <= cur_col - 1'b1;
              end
              B_TAB: begin
                if (cur_col < cols_used) state <= S_TAB;
              end
              B_CR: begin
                cur_col <= '0;
              end
              B_ESC: begin
                phase <= PH_ESC;
              end
              default: begin
                // LF, or a printable with a wrap pending
                if (it_byte == B_LF || cur_col >= cols_used) begin
                  pend_print <= (it_byte != B_LF);
                  cur_col    <= '0;
                  if (at_bottom) begin
                    addr     <= '0;
                    copy_end <= AC'(rows_used - 1'b1) * COLS_C;
                    fill_end <= AC'(rows_used) * COLS_C;
                    state    <= S_SCROLL;
                  end else begin
                    cur_row <= cur_row + 1'b1;
                    if (it_byte != B_LF) state <= S_PUT;
                  end
                end else begin
                  state <= S_PUT;
                end
              end
            endcase
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_TAB: begin
          cur_col <= col_inc;
          if (!(col_inc < cols_used && col_inc[2:0] != 3'd0)) begin
            state <= S_EMIT;
          end
        end
        S_SCROLL: begin
          if (addr < copy_end) begin
            state <= S_SCROLL_WR;
          end else if (addr < fill_end) begin
            addr <= addr + 1'b1;
          end else begin
            state <= pend_print ? S_PUT : S_EMIT;
          end
        end
        S_SCROLL_WR: begin
          addr  <= addr + 1'b1;
          state <= S_SCROLL;
        end
        S_PUT: begin
          cur_col <= col_inc;
          state   <= S_EMIT;
        end
        S_SGR: begin
          if (!pen_stat.busy) state <= S_EMIT;
        end
        S_EMIT: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_write) begin
        if (cfg_index == REG_COLUMNS) cols_reg <= cfg_data;
        else                          rows_reg <= cfg_data[6:0];
        if (cur_col > new_cols) cur_col <= new_cols;
        if (RUW'(cur_row) >= new_rows) cur_row <= RW'(new_rows - 1'b1);
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_when_empty: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !out_valid)
    else $error("transfer taken while a result is pending");

  a_accept_starts_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EXEC))
    else $error("sequencer did not start on a transfer");

  a_row_in_screen: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (RUW'(cur_row) < rows_used) && (cur_col <= cols_used))
    else $error("cursor beyond the screen at result time");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_outside) |-> (cell_char == 8'd0) && (cell_attr == 22'd0))
    else $error("outside read returned cell data");
`endif

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the terminal screen engine: predicts screen, cursor and pen for each
// byte or cell read, and compares every result transfer field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import tese_pkg::*;

  localparam int NCOLS = 128;
  localparam int NROWS = 64;
  localparam int NTOK  = 16;
  localparam int OP_BYTE = 0;
  localparam int OP_READ = 1;

  typedef struct packed {
    logic       op;
    logic [7:0] b;
    logic [5:0] r;
    logic [6:0] c;
  } term_item_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic [21:0] at;
    logic [7:0]  ccol;
    logic [5:0]  crow;
    logic        outside;
  } screen_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = REG_COLUMNS;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = 1'b0;
  logic [7:0] data_byte = '0;
  logic [5:0] read_row = '0;
  logic [6:0] read_col = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [7:0] cell_char;
  logic [21:0] cell_attr;
  logic [7:0] cursor_col;
  logic [5:0] cursor_row;
  logic read_outside;

  terminal_escape_screen_engine dut (.*);

  // predicted state
  logic [7:0]  scr_ch [NCOLS*NROWS];
  logic [21:0] scr_at [NCOLS*NROWS];
  int unsigned ccol, crow, phase, tok_n, ncols_cfg, nrows_cfg;
  logic [21:0] pen;
  int unsigned toks [NTOK];

  term_item_t   pending_items[$];
  screen_resp_t expected_resps[$];
  int errors = 0;
  int hold_cycles = 0;
  bit long_hold = 0;
  bit long_hold_done = 0;

  function automatic int unsigned cols_in_use();
    return ncols_cfg < 1 ? 1 : (ncols_cfg > NCOLS ? NCOLS : ncols_cfg);
  endfunction
  function automatic int unsigned rows_in_use();
    return nrows_cfg < 1 ? 1 : (nrows_cfg > NROWS ? NROWS : nrows_cfg);
  endfunction

  function automatic void put_cell(int unsigned r, int unsigned c, logic [7:0] ch);
    scr_ch[r*NCOLS+c] = ch;
    scr_at[r*NCOLS+c] = pen;
  endfunction

  function automatic void line_feed();
    int unsigned rows;
    rows = rows_in_use();
    ccol = 0;
    crow++;
    if (crow >= rows) begin
      for (int i = 0; i < (rows-1)*NCOLS; i++) begin
        scr_ch[i] = scr_ch[i+NCOLS];
        scr_at[i] = scr_at[i+NCOLS];
      end
      for (int c = 0; c < NCOLS; c++) put_cell(rows-1, c, CH_SPACE);
      crow = rows - 1;
    end
  endfunction

  function automatic logic [21:0] pen_update(logic [21:0] p, int unsigned v);
    if (v == 0) p = PEN_RESET;
    else if (v >= 1 && v <= 5) p[15+v] = 1'b1;
    else if (v == 7) p[21] = 1'b1;
    else if (v >= 21 && v <= 25) p[v-5] = 1'b0;
    else if (v == 27) p[21] = 1'b0;
    else if (v >= 30 && v <= 37) p[7:0] = 8'(v - 30);
    else if (v == 39) p[7:0] = 8'hff;
    else if (v >= 40 && v <= 47) p[15:8] = 8'(v - 40);
    else if (v == 49) p[15:8] = 8'hff;
    return p;
  endfunction

  function automatic void plain_byte(logic [7:0] b);
    int unsigned cols;
    cols = cols_in_use();
    case (b)
      B_NUL: ;
      B_BS: if (ccol != 0) ccol--;
      B_TAB: if (ccol < cols) begin
        do begin
          put_cell(crow, ccol, CH_SPACE);
          ccol++;
        end while (ccol < cols && (ccol % 8) != 0);
      end
      B_LF: line_feed();
      B_CR: ccol = 0;
      B_ESC: phase = PH_ESC;
      default: begin
        if (ccol >= cols) line_feed();
        put_cell(crow, ccol, b);
        ccol++;
      end
    endcase
  endfunction

  function automatic void terminal_byte(logic [7:0] b);
    int unsigned v;
    if (phase == PH_ESC) begin
      if (b == B_LBR) begin
        phase = PH_CSI; tok_n = 0; toks[0] = 0;
        return;
      end
    end else if (phase == PH_CSI) begin
      if (b >= B_ZERO && b <= B_NINE) begin
        v = toks[tok_n] * 10 + (b - B_ZERO);
        toks[tok_n] = v > 65535 ? 65535 : v;
        return;
      end
      if (b == B_SEMI) begin
        if (tok_n + 1 < NTOK) begin
          tok_n++; toks[tok_n] = 0;
          return;
        end
      end else if (b == B_M) begin
        for (int i = 0; i <= tok_n; i++) pen = pen_update(pen, toks[i]);
        phase = PH_GROUND;
        return;
      end
    end else begin
      plain_byte(b);
      return;
    end
    phase = PH_GROUND;
    plain_byte(b);
  endfunction

  function automatic screen_resp_t predict_screen(term_item_t it);
    screen_resp_t e;
    e = '0;
    if (it.op == OP_BYTE) terminal_byte(it.b);
    else if (it.r >= rows_in_use() || it.c >= cols_in_use()) e.outside = 1'b1;
    else begin
      e.ch = scr_ch[it.r*NCOLS+it.c];
      e.at = scr_at[it.r*NCOLS+it.c];
    end
    e.ccol = ccol[7:0];
    e.crow = crow[5:0];
    return e;
  endfunction

  // clamps the predicted cursor as the block does on a register write
  task automatic write_reg(logic [0:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_write <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_COLUMNS) ncols_cfg = val;
    else nrows_cfg = val & 8'h7f;
    if (ccol > cols_in_use()) ccol = cols_in_use();
    if (crow >= rows_in_use()) crow = rows_in_use() - 1;
  endtask

  task automatic push_byte(logic [7:0] b);
    term_item_t it;
    it = '0; it.op = OP_BYTE; it.b = b;
    it.r = 6'($urandom); it.c = 7'($urandom);
    pending_items.push_back(it);
  endtask
  task automatic push_read(int unsigned r, int unsigned c);
    term_item_t it;
    it = '0; it.op = OP_READ; it.r = r[5:0]; it.c = c[6:0];
    it.b = 8'($urandom);
    pending_items.push_back(it);
  endtask
  task automatic push_sgr(int unsigned ntok);
    push_byte(B_ESC); push_byte(B_LBR);
    for (int i = 0; i < ntok; i++) begin
      int unsigned v;
      if (i) push_byte(B_SEMI);
      case ($urandom_range(0, 5))
        0: v = $urandom_range(0, 7);
        1: v = $urandom_range(21, 27);
        2: v = $urandom_range(30, 39);
        3: v = $urandom_range(40, 49);
        4: v = $urandom_range(0, 99999);
        default: v = $urandom_range(0, 60);
      endcase
      if (v == 0 && $urandom_range(0, 1)) continue;
      begin
        string s;
        s = $sformatf("%0d", v);
        for (int k = 0; k < s.len(); k++) push_byte(s[k]);
      end
    end
    push_byte($urandom_range(0, 9) ? B_M : 8'($urandom));
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_resps.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 35) push_byte(8'($urandom_range(32, 126)));
      else if (p < 45) push_sgr($urandom_range(1, 4));
      else if (p < 48) push_byte(B_TAB);
      else if (p < 51) push_byte(B_LF);
      else if (p < 53) push_byte(B_CR);
      else if (p < 55) push_byte(B_BS);
      else if (p < 60) push_byte(8'($urandom));
      else push_read($urandom_range(0, rows_in_use()),
                     $urandom_range(0, cols_in_use()));
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  // driver: predicts at the transfer so config writes see the right state
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_resps.push_back(predict_screen(pending_items.pop_front()));
      end
      if ((!in_valid || !in_stall) ) begin
        if (in_valid && !in_stall) begin
          if (pending_items.size() != 0 && $urandom_range(0, 3) != 0) begin
            opcode <= pending_items[0].op; data_byte <= pending_items[0].b;
            read_row <= pending_items[0].r; read_col <= pending_items[0].c;
            in_valid <= 1'b1;
          end else in_valid <= 1'b0;
        end else if (pending_items.size() != 0 && $urandom_range(0, 2) == 0) begin
          opcode <= pending_items[0].op; data_byte <= pending_items[0].b;
          read_row <= pending_items[0].r; read_col <= pending_items[0].c;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // monitor and sink stalling
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected result transfer", $time);
          errors++;
        end else begin
          screen_resp_t e;
          e = expected_resps.pop_front();
          if (cell_char !== e.ch || cell_attr !== e.at || cursor_col !== e.ccol ||
              cursor_row !== e.crow || read_outside !== e.outside) begin
            $display("%0t: mismatch exp ch=%h at=%h col=%0d row=%0d out=%b",
                     $time, e.ch, e.at, e.ccol, e.crow, e.outside);
            $display("%0t:          got ch=%h at=%h col=%0d row=%0d out=%b",
                     $time, cell_char, cell_attr, cursor_col, cursor_row, read_outside);
            errors++;
          end
        end
      end
      if (long_hold && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_cycles <= 400;
        out_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < 3) begin
        hold_cycles <= $urandom_range(10, 60);
        out_stall <= 1'b1;
      end else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    for (int i = 0; i < NCOLS*NROWS; i++) begin
      scr_ch[i] = CH_SPACE; scr_at[i] = PEN_RESET;
    end
    ccol = 0; crow = 0; phase = PH_GROUND; tok_n = 0; pen = PEN_RESET;
    ncols_cfg = 80; nrows_cfg = 24;
    foreach (toks[i]) toks[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_COLUMNS, 8'd20);
    write_reg(REG_ROWS, 7'd4);
    // directed: controls, sequences, malformed and saturating cases
    push_byte(8'h41); push_byte(B_TAB); push_byte(B_BS); push_byte(8'hff);
    push_byte(B_NUL); push_byte(B_ESC); push_byte(8'h41);
    push_byte(B_ESC); push_byte(B_LBR); push_byte(8'h31); push_byte(B_SEMI);
    push_byte(8'h33); push_byte(8'h31); push_byte(B_M);
    push_byte(B_ESC); push_byte(B_LBR);
    for (int i = 0; i < 7; i++) push_byte(8'h39);
    push_byte(8'h78);
    push_byte(B_LF); push_byte(B_CR); push_read(0, 0); push_read(63, 127);
    drain();
    // too many tokens
    push_byte(B_ESC); push_byte(B_LBR);
    for (int i = 0; i < 16; i++) push_byte(B_SEMI);
    push_read(0, 0);
    // receiver holds off long while items keep coming
    long_hold = 1'b1;
    for (int i = 0; i < 30; i++) push_byte(8'h61);
    repeat (5) push_byte(B_LF);
    drain();
    write_reg(REG_COLUMNS, 8'd128); write_reg(REG_ROWS, 7'd64);
    random_phase(160); drain();
    write_reg(REG_COLUMNS, 8'd1); write_reg(REG_ROWS, 7'd1);
    random_phase(130); drain();
    write_reg(REG_COLUMNS, 8'd0); write_reg(REG_ROWS, 7'd127);
    random_phase(130); drain();
    write_reg(REG_COLUMNS, 8'd255); write_reg(REG_ROWS, 7'd2);
    random_phase(130); drain();
    write_reg(REG_COLUMNS, 8'($urandom_range(8, 40)));
    write_reg(REG_ROWS, 7'($urandom_range(2, 10)));
    random_phase(260); drain();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #400ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* terminal_escape_screen_engine.f */
hdl/tese_pkg.sv
hdl/tese_ram.sv
hdl/tese_pen.sv
hdl/terminal_escape_screen_engine.sv
tb/tb_top.sv
